FILE: hw/rtl/sesc_pkg.sv
// Shared types, constants and character functions for the string escaper.
package sesc_pkg;

   localparam int MAX_UNITS  = 4;
   localparam int HELD_DEPTH = 3;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_HEX_A  = 8'h57;  // 'a' minus ten
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // How one byte of a job is turned into characters.
   typedef enum logic [1:0] {
      UNIT_RAW,     // passes unchanged
      UNIT_SINGLE,  // named escape, hex escape or unchanged, by value
      UNIT_HEX      // always a hex escape
   } unit_kind_type;

   typedef struct packed {
      logic [7:0]    data;
      unit_kind_type kind;
   } unit_type;

   // Work handed from the front to the back: up to four bytes for one item.
   typedef struct packed {
      unit_type [MAX_UNITS-1:0] units;
      logic [2:0]               count;
      logic                     eos;
   } job_type;

   // Length of a sequence starting with this lead, or zero if it cannot start one.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b[7:5] == 3'b110) begin
         len = (b >= 8'hC2) ? 3'd2 : 3'd0;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = (b <= 8'hF4) ? 3'd4 : 3'd0;
      end
      return len;
   endfunction

   // Second character of a named escape, or zero when the byte has none.
   function automatic logic [7:0] named_escape(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         8'h22:   c = CHAR_QUOTE;
         8'h5C:   c = CHAR_BSLASH;
         8'h08:   c = 8'h62;
         8'h0C:   c = 8'h66;
         8'h0A:   c = 8'h6E;
         8'h0D:   c = 8'h72;
         8'h09:   c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      return (n < 4'd10) ? (CHAR_ZERO + {4'h0, n}) : (CHAR_HEX_A + {4'h0, n});
   endfunction

   function automatic logic needs_hex(input logic [7:0] b);
      return (b < CHAR_SPACE) || (b >= CHAR_DEL);
   endfunction

   // Number of output characters one unit produces (1 to 4).
   function automatic logic [2:0] unit_chars(input unit_kind_type kind, input logic [7:0] b);
      logic [2:0] n;
      case (kind)
         UNIT_RAW:    n = 3'd1;
         UNIT_HEX:    n = 3'd4;
         UNIT_SINGLE: begin
            if (named_escape(b) != 8'h00) n = 3'd2;
            else if (needs_hex(b))        n = 3'd4;
            else                          n = 3'd1;
         end
         default:     n = 3'd1;
      endcase
      return n;
   endfunction

   // Character at position idx of the text one unit produces.
   function automatic logic [7:0] unit_char(input unit_kind_type kind, input logic [7:0] b,
                                            input logic [1:0] idx);
      logic [7:0] named;
      logic       hex;
      logic [7:0] c;
      named = named_escape(b);
      hex   = (kind == UNIT_HEX) || ((kind == UNIT_SINGLE) && (named == 8'h00) && needs_hex(b));
      if (hex) begin
         case (idx)
            2'd0:    c = CHAR_BSLASH;
            2'd1:    c = CHAR_X;
            2'd2:    c = hex_digit(b[7:4]);
            default: c = hex_digit(b[3:0]);
         endcase
      end else if ((kind == UNIT_SINGLE) && (named != 8'h00)) begin
         c = (idx == 2'd0) ? CHAR_BSLASH : named;
      end else begin
         c = b;
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/sesc_if.sv
// Handshake interfaces for the byte input channel and the character output channel.
interface sesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface sesc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       string_done;

   modport source (output valid, output out_char, output run_last, output string_done,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input string_done,
                   output ready);
endinterface

FILE: hw/rtl/string_escaper_utf8_checked.sv
// Top level of the streaming string escaper with UTF-8 checking.
//
// Bytes of a string enter on req_chan (in_byte, end_of_string) and escaped
// characters leave on rsp_chan (out_char, run_last, string_done), both with a
// valid/ready handshake. An item is taken at a clock edge with valid and ready
// high. A byte that completes a valid UTF-8 sequence releases the whole
// sequence unchanged; a byte that is held as part of a pending sequence gives
// no character. Escapes and flushed sequences give up to sixteen characters.
// An item's job is written into the job queue, and its characters are then presented
// from the output register. The character generator emits one character per cycle
// while the receiver is ready; an item gives one character for plain text and at most
// sixteen. A job queue of QueueDepth entries lets the input run ahead of the output;
// req_chan.ready drops only while that queue is full.
// When the receiver stalls, the output register holds its character and the
// queue fills, after which the input stalls too. Reset empties the queue and
// the output register and drops any pending sequence.
module string_escaper_utf8_checked #(
   parameter int QueueDepth = 2
) (
   input  logic       clock,
   input  logic       reset,
   sesc_req_if.sink   req_chan,
   sesc_rsp_if.source rsp_chan
);

   logic              push;
   logic              full;
   logic              head_valid;
   logic              pop;
   sesc_pkg::job_type push_job;
   sesc_pkg::job_type head_job;

   sesc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .job        (push_job)
   );

   sesc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   sesc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: hw/rtl/sesc_front.sv
// Front end: accepts bytes, tracks the pending UTF-8 sequence and issues jobs.
module sesc_front (
   input  logic              clock,
   input  logic              reset,
   sesc_req_if.sink          req_chan,
   input  logic              queue_full,
   output logic              push,
   output sesc_pkg::job_type job
);

   logic [7:0] held_ff [sesc_pkg::HELD_DEPTH];
   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] expected_ff, expected_in;
   logic       held_we;
   logic [1:0] held_idx;

   logic       accept;
   logic [7:0] b;
   logic       eos;
   logic [2:0] len;
   logic       start;
   logic       ok;
   logic       complete;

   always_comb begin
      req_chan.ready = !queue_full;
      accept   = req_chan.valid && !queue_full;
      b        = req_chan.in_byte;
      eos      = req_chan.end_of_string;
      len      = sesc_pkg::lead_length(b);
      start    = (len != 3'd0) && !eos;
      complete = (({1'b0, held_count_ff} + 3'd1) == expected_ff);

      ok = (b[7:6] == 2'b10);
      if (held_count_ff == 2'd1) begin
         if (held_ff[0] == 8'hE0 && b <  8'hA0) ok = 1'b0;
         if (held_ff[0] == 8'hED && b >= 8'hA0) ok = 1'b0;
         if (held_ff[0] == 8'hF0 && b <  8'h90) ok = 1'b0;
         if (held_ff[0] == 8'hF4 && b >= 8'h90) ok = 1'b0;
      end

      job.eos   = eos;
      job.count = 3'd0;
      for (int i = 0; i < sesc_pkg::HELD_DEPTH; i++) begin
         job.units[i].data = held_ff[i];
         job.units[i].kind = sesc_pkg::UNIT_HEX;
      end
      job.units[sesc_pkg::MAX_UNITS-1].data = b;
      job.units[sesc_pkg::MAX_UNITS-1].kind = sesc_pkg::UNIT_HEX;
      job.units[held_count_ff].data = b;

      held_count_in = held_count_ff;
      expected_in   = expected_ff;
      held_we       = 1'b0;
      held_idx      = held_count_ff;

      if (held_count_ff == 2'd0) begin
         if (start) begin
            held_we       = 1'b1;
            held_count_in = 2'd1;
            expected_in   = len;
         end else begin
            job.count         = 3'd1;
            job.units[0].kind = sesc_pkg::UNIT_SINGLE;
         end
      end else if (ok && complete) begin
         for (int i = 0; i < sesc_pkg::MAX_UNITS; i++) begin
            job.units[i].kind = sesc_pkg::UNIT_RAW;
         end
         job.count     = {1'b0, held_count_ff} + 3'd1;
         held_count_in = 2'd0;
         expected_in   = 3'd0;
      end else if (ok && eos) begin
         job.count     = {1'b0, held_count_ff} + 3'd1;
         held_count_in = 2'd0;
         expected_in   = 3'd0;
      end else if (ok) begin
         held_we       = 1'b1;
         held_count_in = held_count_ff + 2'd1;
      end else begin
         // Failed continuation: flush the held bytes, then treat this byte as fresh.
         job.count     = {1'b0, held_count_ff};
         held_count_in = 2'd0;
         expected_in   = 3'd0;
         if (start) begin
            held_we       = 1'b1;
            held_idx      = 2'd0;
            held_count_in = 2'd1;
            expected_in   = len;
         end else begin
            job.units[held_count_ff].kind = sesc_pkg::UNIT_SINGLE;
            job.count = {1'b0, held_count_ff} + 3'd1;
         end
      end

      push = accept && (job.count != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         expected_ff   <= 3'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         expected_ff   <= expected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_we) begin
         held_ff[held_idx] <= b;
      end
   end

   a_idle_no_length: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff == 2'd0) |-> (expected_ff == 3'd0))
      else $error("expected length set with no held bytes");

   a_held_below_length: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff != 2'd0) |-> (({1'b0, held_count_ff} < expected_ff) && (expected_ff <= 3'd4)))
      else $error("held byte count not below sequence length");

endmodule

FILE: hw/rtl/sesc_queue.sv
// Small job queue that decouples the front end from the character generator.
module sesc_queue #(
   parameter int Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sesc_pkg::job_type push_job,
   output logic              full,
   output logic              head_valid,
   output sesc_pkg::job_type head_job,
   input  logic              pop
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   sesc_pkg::job_type     entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == CountWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

endmodule

FILE: hw/rtl/sesc_back.sv
// Back end: expands the head job into output characters, one per cycle while the receiver is ready.
module sesc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sesc_pkg::job_type head_job,
   output logic              pop,
   sesc_rsp_if.source        rsp_chan
);

   logic [1:0] unit_ff;
   logic [1:0] char_ff;
   logic       rsp_valid_ff;
   logic [7:0] out_char_ff;
   logic       run_last_ff;
   logic       string_done_ff;

   sesc_pkg::unit_type cur_unit;
   logic [2:0]         n_chars;
   logic               last_char;
   logic               last_unit;
   logic               load;
   logic               run_last_in;

   always_comb begin
      cur_unit    = head_job.units[unit_ff];
      n_chars     = sesc_pkg::unit_chars(cur_unit.kind, cur_unit.data);
      last_char   = ({1'b0, char_ff} == (n_chars - 3'd1));
      last_unit   = ({1'b0, unit_ff} == (head_job.count - 3'd1));
      load        = head_valid && (!rsp_valid_ff || rsp_chan.ready);
      run_last_in = last_char && last_unit;
      pop         = load && run_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff      <= 2'd0;
         char_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            if (last_char) begin
               char_ff <= 2'd0;
               unit_ff <= last_unit ? 2'd0 : unit_ff + 2'd1;
            end else begin
               char_ff <= char_ff + 2'd1;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_char_ff    <= sesc_pkg::unit_char(cur_unit.kind, cur_unit.data, char_ff);
         run_last_ff    <= run_last_in;
         string_done_ff <= run_last_in && head_job.eos;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.run_last    = run_last_ff;
   assign rsp_chan.string_done = string_done_ff;

   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && string_done_ff) |-> run_last_ff)
      else $error("string end flagged on a character that does not end its run");

endmodule
